### sv/qoi_pkg.sv
// shared types, constants and operand table of the quaternion integrator
package qoi_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int QW = 32;

    typedef struct packed {
        logic [1:0] qidx;
        logic       neg;
    } mac_sel_t;

    // kinematic matrix: stored component and sign for term t of delta component c
    function automatic mac_sel_t mac_sel(input logic [1:0] c, input logic [1:0] t);
        mac_sel_t r;
        r = '{qidx: 2'd0, neg: 1'b0};
        case ({c, t})
            4'b0000: r = '{qidx: 2'd1, neg: 1'b1};
            4'b0001: r = '{qidx: 2'd2, neg: 1'b1};
            4'b0010: r = '{qidx: 2'd3, neg: 1'b1};
            4'b0100: r = '{qidx: 2'd0, neg: 1'b0};
            4'b0101: r = '{qidx: 2'd3, neg: 1'b0};
            4'b0110: r = '{qidx: 2'd2, neg: 1'b1};
            4'b1000: r = '{qidx: 2'd3, neg: 1'b1};
            4'b1001: r = '{qidx: 2'd0, neg: 1'b0};
            4'b1010: r = '{qidx: 2'd1, neg: 1'b0};
            4'b1100: r = '{qidx: 2'd2, neg: 1'b0};
            4'b1101: r = '{qidx: 2'd1, neg: 1'b1};
            4'b1110: r = '{qidx: 2'd0, neg: 1'b0};
            default: r = '{qidx: 2'd0, neg: 1'b0};
        endcase
        return r;
    endfunction

endpackage

### sv/qoi_mul.sv
// shared registered signed 32x32 multiplier
module qoi_mul
    import qoi_pkg::*;
(
    input  logic                 clk,
    input  logic signed [QW-1:0] a,
    input  logic signed [QW-1:0] b,
    output logic signed [2*QW-1:0] prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

### sv/qoi_isqrt.sv
// iterative integer square root, two radicand bits per cycle
module qoi_isqrt
    import qoi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [63:0]     n,
    output logic            done,
    output logic [QW-1:0]   root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] n_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[32:0], n_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= n;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[61:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### sv/qoi_div.sv
// restoring divider: saturated floor(num * 2^FRAC_BITS / den), one bit per cycle
module qoi_div
    import qoi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] num,
    input  logic [QW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [32:0]   r_reg;
    logic [31:0]   q_reg;
    logic          sat_reg;
    logic [31:0]   den_reg;
    logic [32:0]   r_sh;
    logic          bit_ge;

    assign r_sh   = {r_reg[31:0], 1'b0};
    assign bit_ge = r_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            sat_reg <= 1'b0;
            // integer part is 0 or 1 since num never exceeds den
            if (num >= den)
            begin
                r_reg <= {1'b0, num - den};
                q_reg <= 32'd1;
            end
            else
            begin
                r_reg <= {1'b0, num};
                q_reg <= 32'd0;
            end
        end
        else if (busy_reg)
        begin
            r_reg   <= bit_ge ? r_sh - {1'b0, den_reg} : r_sh;
            q_reg   <= {q_reg[30:0], bit_ge};
            sat_reg <= sat_reg | q_reg[31] | q_reg[30];
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? 32'h7fff_ffff : q_reg;

endmodule

### sv/quaternion_orientation_integrator.sv
// Quaternion orientation integrator: first-order attitude propagation with renormalization.
// Input channel s_*: tuser carries cmd (0 integrate, 1 load); tdata carries incr_x, incr_y,
// incr_z, load_w, load_x, load_y, load_z, 32 bits each from the lowest bit up.
// Output channel m_*: one transaction per input transaction, tdata carries out_w, out_x,
// out_y, out_z, tuser carries zero_length.
// A load transaction goes from acceptance to the output stage ST_OUT and then to the output
// register. An integrate transaction runs multiply-accumulate through one shared 32x32
// multiplier, then the squared length, the square root unit (two bits per cycle) and four
// divisions in one bit-serial divider.
// One item is processed at a time; s_tready is high only while the block is idle.
// The result sits in an output register, so the block takes the next item while the
// previous result still waits; if the receiver stalls for longer, the block holds its
// finished result and waits before presenting it.
// Reset sets the stored quaternion to unity (one, zero, zero, zero) and empties the output.
module quaternion_orientation_integrator
    import qoi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // incr_x, incr_y, incr_z, load_w, load_x, load_y, load_z
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_w, out_x, out_y, out_z
    output logic         m_tuser    // zero_length
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic [QW-1:0] UNITY = (FRAC_BITS >= 31) ? 32'h7fff_ffff : ONE64[QW-1:0];

    logic [2:0] state_reg;
    logic signed [QW-1:0] q_reg [0:3];
    logic signed [QW-1:0] s_reg [0:3];
    logic signed [QW-1:0] v_reg [0:2];
    logic signed [65:0]   acc_reg;
    logic [63:0]          l2_reg;
    logic [QW-1:0]        len_reg;
    logic                 flag_reg;
    logic [1:0]           comp_reg;
    logic [1:0]           term_reg;
    logic                 iss_on_reg;
    logic                 pv_reg;
    logic [1:0]           pc_reg;
    logic [1:0]           pt_reg;
    logic                 pn_reg;
    logic                 launched_reg;
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;
    logic                 m_tuser_reg;

    mac_sel_t             sel;
    logic signed [QW-1:0] mul_a;
    logic signed [QW-1:0] mul_b;
    logic signed [63:0]   prod;
    logic signed [65:0]   prod_ext;
    logic signed [65:0]   acc_next;
    logic signed [65:0]   delta;
    logic signed [65:0]   sum;
    logic signed [QW-1:0] sum_sat;
    logic [63:0]          l2_next;
    logic                 accept;
    logic                 unit_start;
    logic                 root_done;
    logic [QW-1:0]        root;
    logic                 div_done;
    logic [QW-1:0]        quot;
    logic [QW-1:0]        div_num;
    logic                 out_free;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = state_reg == ST_IDLE;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign unit_start = (state_reg == ST_ROOT || state_reg == ST_DIV) && !launched_reg;

    assign sel = mac_sel(comp_reg, term_reg);

    always_comb
    begin
        if (state_reg == ST_SQ)
        begin
            mul_a = s_reg[comp_reg];
            mul_b = s_reg[comp_reg];
        end
        else
        begin
            mul_a = q_reg[sel.qidx];
            mul_b = v_reg[term_reg];
        end
    end

    qoi_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // half step rounded toward minus infinity, then symmetric saturation
    always_comb
    begin
        prod_ext = {{2{prod[63]}}, prod};
        acc_next = ((pt_reg == 2'd0) ? 66'sd0 : acc_reg) + (pn_reg ? -prod_ext : prod_ext);
        delta    = acc_next >>> (FRAC_BITS + 1);
        sum      = {{34{q_reg[pc_reg][QW-1]}}, q_reg[pc_reg]} + delta;
        if (sum > 66'sd2147483647)
            sum_sat = 32'sh7fff_ffff;
        else if (sum < -66'sd2147483647)
            sum_sat = 32'sh8000_0001;
        else
            sum_sat = sum[QW-1:0];
        l2_next = l2_reg + prod[63:0];
    end

    assign div_num = s_reg[comp_reg][QW-1] ? -s_reg[comp_reg] : s_reg[comp_reg];

    qoi_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start && state_reg == ST_ROOT),
        .n     (l2_reg),
        .done  (root_done),
        .root  (root)
    );

    qoi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start && state_reg == ST_DIV),
        .num   (div_num),
        .den   (len_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            q_reg[0]     <= UNITY;
            q_reg[1]     <= '0;
            q_reg[2]     <= '0;
            q_reg[3]     <= '0;
            flag_reg     <= 1'b0;
            comp_reg     <= '0;
            term_reg     <= '0;
            iss_on_reg   <= 1'b0;
            pv_reg       <= 1'b0;
            pc_reg       <= '0;
            pt_reg       <= '0;
            pn_reg       <= 1'b0;
            launched_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (unit_start)
                launched_reg <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        flag_reg <= 1'b0;
                        comp_reg <= '0;
                        term_reg <= '0;
                        if (s_tuser)
                        begin
                            q_reg[0]  <= s_tdata[127:96];
                            q_reg[1]  <= s_tdata[159:128];
                            q_reg[2]  <= s_tdata[191:160];
                            q_reg[3]  <= s_tdata[223:192];
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            iss_on_reg <= 1'b1;
                            state_reg  <= ST_MAC;
                        end
                    end
                end

                ST_MAC, ST_SQ:
                begin
                    pv_reg <= iss_on_reg;
                    pc_reg <= comp_reg;
                    pt_reg <= term_reg;
                    pn_reg <= sel.neg;
                    if (iss_on_reg)
                    begin
                        if (state_reg == ST_SQ || term_reg == 2'd2)
                        begin
                            term_reg <= '0;
                            comp_reg <= comp_reg + 2'd1;
                            if (comp_reg == 2'd3)
                                iss_on_reg <= 1'b0;
                        end
                        else
                        begin
                            term_reg <= term_reg + 2'd1;
                        end
                    end
                    if (pv_reg && state_reg == ST_MAC && pt_reg == 2'd2 && pc_reg == 2'd3)
                    begin
                        // all four sums done, start the squared length
                        iss_on_reg <= 1'b1;
                        pv_reg     <= 1'b0;
                        comp_reg   <= '0;
                        term_reg   <= '0;
                        state_reg  <= ST_SQ;
                    end
                    if (pv_reg && state_reg == ST_SQ && pc_reg == 2'd3)
                    begin
                        pv_reg   <= 1'b0;
                        comp_reg <= '0;
                        if (l2_next == 64'd0)
                        begin
                            q_reg[0]  <= UNITY;
                            q_reg[1]  <= '0;
                            q_reg[2]  <= '0;
                            q_reg[3]  <= '0;
                            flag_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_ROOT;
                        end
                    end
                end

                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        launched_reg <= 1'b0;
                        state_reg    <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        launched_reg    <= 1'b0;
                        q_reg[comp_reg] <= s_reg[comp_reg][QW-1] ? -quot : quot;
                        comp_reg        <= comp_reg + 2'd1;
                        if (comp_reg == 2'd3)
                            state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg[0] <= s_tdata[31:0];
            v_reg[1] <= s_tdata[63:32];
            v_reg[2] <= s_tdata[95:64];
            l2_reg   <= '0;
        end
        if (state_reg == ST_MAC && pv_reg)
        begin
            acc_reg <= acc_next;
            if (pt_reg == 2'd2)
                s_reg[pc_reg] <= sum_sat;
        end
        if (state_reg == ST_SQ && pv_reg)
            l2_reg <= l2_next;
        if (state_reg == ST_ROOT && root_done)
            len_reg <= root;
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
            m_tuser_reg <= flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> state_reg == ST_OUT)
        else $error("load transaction did not go straight to output");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> len_reg != '0)
        else $error("division started with zero length");

    a_zero_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata == {96'd0, UNITY})
        else $error("zero length result is not unity");

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_free) |=> state_reg == ST_OUT)
        else $error("result left the output stage while the receiver stalled");

endmodule

### tb/attitude_checker.sv
// checker for the quaternion integrator: predicts each result and compares it
`timescale 1ns / 100ps

module attitude_checker
    import qoi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [223:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         m_tuser,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        zero_len;
    } attitude_t;

    localparam longint MAXV = 64'sd2147483647;

    longint    quat [4];
    attitude_t expected_q [$];

    function automatic longint unity();
        return (FRAC_BITS >= 31) ? MAXV : (64'sd1 <<< FRAC_BITS);
    endfunction

    function automatic longint clamp_sym(input longint v);
        if (v > MAXV)
            return MAXV;
        if (v < -MAXV)
            return -MAXV;
        return v;
    endfunction

    // exact floor((a+b+c) / 2^(FRAC_BITS+1)) using 128-bit sum
    function automatic longint half_delta(input longint a, input longint b, input longint c);
        logic signed [127:0] s;
        s = 128'(a) + 128'(b) + 128'(c);
        s = s >>> (FRAC_BITS + 1);
        return longint'(s);
    endfunction

    function automatic longint root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint unit_scale(input longint s, input longint len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (s < 0) ? 128'(-s) : 128'(s);
        q = (mag << FRAC_BITS) / 128'(len);
        if (q > 128'h7FFFFFFF)
            q = 128'h7FFFFFFF;
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic attitude_t advance(input logic cmd, input logic [223:0] d);
        attitude_t   r;
        longint      vx, vy, vz, w, x, y, z, len;
        longint      s [4];
        logic [63:0] l2;
        r.zero_len = 1'b0;
        if (cmd)
        begin
            for (int i = 0; i < 4; i++)
                quat[i] = longint'($signed(d[96 + 32*i +: 32]));
        end
        else
        begin
            vx = longint'($signed(d[31:0]));
            vy = longint'($signed(d[63:32]));
            vz = longint'($signed(d[95:64]));
            w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
            s[0] = clamp_sym(w + half_delta(-(x*vx), -(y*vy), -(z*vz)));
            s[1] = clamp_sym(x + half_delta(w*vx, z*vy, -(y*vz)));
            s[2] = clamp_sym(y + half_delta(-(z*vx), w*vy, x*vz));
            s[3] = clamp_sym(z + half_delta(y*vx, -(x*vy), w*vz));
            l2 = 0;
            for (int i = 0; i < 4; i++)
                l2 += 64'(s[i] * s[i]);
            if (l2 == 0)
            begin
                quat[0] = unity(); quat[1] = 0; quat[2] = 0; quat[3] = 0;
                r.zero_len = 1'b1;
            end
            else
            begin
                len = root_floor(l2);
                for (int i = 0; i < 4; i++)
                    quat[i] = unit_scale(s[i], len);
            end
        end
        r.w = quat[0][31:0]; r.x = quat[1][31:0];
        r.y = quat[2][31:0]; r.z = quat[3][31:0];
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        attitude_t e;
        attitude_t got;
        if (!rst_n)
        begin
            quat[0] = unity(); quat[1] = 0; quat[2] = 0; quat[3] = 0;
            errors <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(advance(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e !== got)
                    begin
                        $display("%0t: mismatch expected w=%h x=%h y=%h z=%h zl=%b",
                                 $time, e.w, e.x, e.y, e.z, e.zero_len);
                        $display("%0t:            actual w=%h x=%h y=%h z=%h zl=%b",
                                 $time, got.w, got.x, got.y, got.z, got.zero_len);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/testbench.sv
// stimulus and verdict for the quaternion integrator
`timescale 1ns / 100ps

module testbench;
    import qoi_pkg::*;

    localparam int  N_RANDOM = 830;
    localparam int  ONE = 1 << FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 5000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    int           errors;
    int           pending;
    longint       cycles = 0;
    bit           hold_rx = 1'b0;
    int           rx_gap = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    quaternion_orientation_integrator u_top (.*);

    attitude_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(ONE);
            3: return -32'(ONE);
            4: return 32'($signed($urandom_range(0, 2047)) - 1024);
            5: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls of random length, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n || hold_rx)
            m_tready <= 1'b0;
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= gap_len();
        end
        else
            m_tready <= 1'b1;
    end

    // tvalid stays high between back-to-back transactions
    task automatic push_item(input logic cmd, input logic [223:0] d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic load_quat(input logic [31:0] w, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        push_item(1'b1, {z, y, x, w, rand_word(), rand_word(), rand_word()});
    endtask

    task automatic spin(input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
        push_item(1'b0, {rand_word(), rand_word(), rand_word(), rand_word(), vz, vy, vx});
    endtask

    initial
    begin
        int wait_cycles;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: zero increment from unity, extremes, loads, zero length
        spin(0, 0, 0);
        spin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        spin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        spin(32'(ONE / 100), -32'(ONE / 50), 32'(ONE / 7));
        load_quat(0, 0, 0, 0);
        spin(32'h7FFF_FFFF, 0, 0);
        load_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        spin(32'h8000_0000, 32'h7FFF_FFFF, 0);
        load_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        spin(0, 32'h8000_0000, 32'h7FFF_FFFF);
        load_quat(1, 0, 0, 0);
        spin(0, 0, 0);
        load_quat(0, 0, 0, 0);
        spin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        load_quat(-32'(ONE), 0, 0, 0);
        spin(32'(ONE), 32'(ONE), 32'(ONE));
        load_quat(0, 32'(ONE), 0, 0);
        spin(0, 32'h5555_5555, 32'hAAAA_AAAA);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_rx = 1'b1;
                wait_cycles = 0;
                while (wait_cycles < 1500)
                begin
                    @(posedge clk);
                    wait_cycles++;
                end
                hold_rx = 1'b0;
            end
            begin
                for (int i = 0; i < 4; i++)
                    spin(rand_word(), rand_word(), rand_word());
            end
        join
        // random: mostly small-step integration runs, sometimes loads
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                load_quat(rand_word(), rand_word(), rand_word(), rand_word());
            else if ($urandom_range(0, 3) == 0)
                spin(rand_word(), rand_word(), rand_word());
            else
                spin(32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
                     32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
                     32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
